[design/rpng_pkg.sv]
`default_nettype none
// ============================================================================
// rpng_pkg
// Shared types, constants and helper functions of the RGB565 to stored-PNG
// byte stream encoder.
// ============================================================================
package rpng_pkg;

    // image size limits and register codes
    localparam int unsigned DIM_W         = 15;
    localparam logic [14:0] MAX_DIMENSION = 15'd16384;
    localparam logic [0:0]  REG_WIDTH     = 1'b0;
    localparam logic [0:0]  REG_HEIGHT    = 1'b1;

    // deflate stored block size (reciprocal trick in the back end assumes 2^16-1)
    localparam logic [15:0] STORED_BLOCK_MAX = 16'hFFFF;

    // checksum constants
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_SEED  = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // byte sequence lengths (last index)
    localparam logic [5:0] HDR_LAST = 6'd42;
    localparam logic [5:0] TRL_LAST = 6'd19;
    localparam logic [2:0] BLK_LAST = 3'd4;
    localparam logic [1:0] RAW_LAST = 2'd3;

    // command queue between front and back
    localparam int unsigned CMD_DEPTH = 4;
    localparam int unsigned CMD_AW    = 2;

    // one command from the front end
    typedef struct packed {
        logic        start;      // emit signature, IHDR and IDAT opening first
        logic        row_start;  // emit the filter byte first
        logic        raw_on;     // emit the three pixel bytes
        logic        trailer;    // emit Adler, IDAT CRC and IEND afterwards
        logic [15:0] pixel;
        logic [14:0] width;
        logic [14:0] height;
    } t_cmd;

    // back end byte sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_RAW  = 4'b0100,
        PH_TRL  = 4'b1000
    } t_phase;

    // CRC-32 (reflected) update by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // 0 reads as 1, anything above the limit as the limit
    function automatic logic [14:0] clamp_dim(input logic [14:0] v);
        logic [14:0] r;
        r = v;
        if (v == 15'd0) begin
            r = 15'd1;
        end else if (v > MAX_DIMENSION) begin
            r = MAX_DIMENSION;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[design/rpng_pix_if.sv]
`default_nettype none
// ============================================================================
// rpng_pix_if
// Pixel channel: valid/ready handshake with one RGB565 pixel.
// ============================================================================
interface rpng_pix_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

[design/rpng_byte_if.sv]
`default_nettype none
// ============================================================================
// rpng_byte_if
// Byte channel: valid/ready handshake with one PNG file byte and its flags.
// ============================================================================
interface rpng_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_end;

    modport source (output valid, output out_byte, output run_last, output file_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input file_end,
                    output ready);
endinterface
`default_nettype wire

[design/rpng_front.sv]
`default_nettype none
// ============================================================================
// rpng_front
// Pixel intake: tracks column and row, latches the image size at image start
// and turns each pixel transfer into one command for the back end.
// ============================================================================
module rpng_front import rpng_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic [14:0] i_cfg_width,
    input  wire logic [14:0] i_cfg_height,
    rpng_pix_if.sink   i_pix,
    input  wire logic  i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic        r_started;
    logic        r_pend;      // trailer of a one-pixel image still owed
    logic [13:0] r_col;
    logic [13:0] r_row;
    logic [14:0] r_cw;
    logic [14:0] r_ch;

    logic        w_start;
    logic [14:0] w_cw;
    logic [14:0] w_ch;
    logic [14:0] w_col_next;
    logic [14:0] w_row_next;
    logic        w_end_row;
    logic        w_last;

    assign i_pix.ready = !i_full;
    assign o_push      = i_pix.valid && !i_full;

    // classify the pixel
    always_comb begin
        w_start    = !r_started;
        w_cw       = w_start ? clamp_dim(i_cfg_width)  : r_cw;
        w_ch       = w_start ? clamp_dim(i_cfg_height) : r_ch;
        w_col_next = {1'b0, r_col} + 15'd1;
        w_row_next = {1'b0, r_row} + 15'd1;
        w_end_row  = (w_col_next >= w_cw);
        w_last     = w_end_row && (w_row_next >= w_ch);

        o_cmd.pixel  = i_pix.pixel;
        o_cmd.width  = w_cw;
        o_cmd.height = w_ch;
        if (r_pend) begin
            o_cmd.start     = 1'b0;
            o_cmd.row_start = 1'b0;
            o_cmd.raw_on    = 1'b0;
            o_cmd.trailer   = 1'b1;
        end else begin
            o_cmd.start     = w_start;
            o_cmd.row_start = (r_col == 14'd0);
            o_cmd.raw_on    = 1'b1;
            // a one-pixel image defers its trailer to the next transfer
            o_cmd.trailer   = w_last && !w_start;
        end
    end

    // position and image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_pend    <= 1'b0;
            r_col     <= 14'd0;
            r_row     <= 14'd0;
            r_cw      <= 15'd1;
            r_ch      <= 15'd1;
        end else if (o_push) begin
            if (r_pend) begin
                r_pend <= 1'b0;
            end else begin
                if (w_start) begin
                    r_started <= 1'b1;
                    r_cw      <= w_cw;
                    r_ch      <= w_ch;
                end
                if (w_end_row) begin
                    r_col <= 14'd0;
                    if (w_last) begin
                        r_row     <= 14'd0;
                        r_started <= 1'b0;
                        r_pend    <= w_start;
                    end else begin
                        r_row <= w_row_next[13:0];
                    end
                end else begin
                    r_col <= w_col_next[13:0];
                end
            end
        end
    end

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_started)
        else $error("trailer pending while an image is open");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && !r_pend && w_last) |=> !r_started)
        else $error("image still open after its last pixel");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> ({1'b0, r_col} < r_cw))
        else $error("column count beyond image width");

endmodule
`default_nettype wire

[design/rpng_cmd_fifo.sv]
`default_nettype none
// ============================================================================
// rpng_cmd_fifo
// Short command queue between the front end and the byte sequencer.
// ============================================================================
module rpng_cmd_fifo import rpng_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wp;
    logic [CMD_AW-1:0] r_rp;
    logic [CMD_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (CMD_AW+1)'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

[design/rpng_back.sv]
`default_nettype none
// ============================================================================
// rpng_back
// Byte sequencer: expands commands into PNG bytes (headers, stored block
// headers, scanline bytes, trailer), keeps CRC-32 and Adler-32, and drives
// the registered byte output.
// ============================================================================
module rpng_back import rpng_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cmd_valid,
    input  wire t_cmd   i_cmd,
    output logic        o_cmd_pop,
    rpng_byte_if.source o_byte
);

    t_phase      r_phase;
    t_cmd        r_cmd;
    logic [5:0]  r_idx;
    logic [1:0]  r_ri;
    logic [2:0]  r_bh;
    logic [31:0] r_crc;
    logic [15:0] r_adl;
    logic [15:0] r_adh;
    logic [15:0] r_blk_left;
    logic [29:0] r_raw_left;

    // size arithmetic, registered in a chain after an image start
    logic [14:0] r_w;
    logic [14:0] r_h;
    logic [15:0] r_rowlen;
    logic [29:0] r_raw;
    logic [30:0] r_rawp;
    logic [14:0] r_blocks;
    logic [30:0] r_idat;

    // output register
    logic        r_ov;
    logic [7:0]  r_ob;
    logic        r_ol;
    logic        r_oe;

    logic        w_adv;
    logic        w_blkhdr;
    logic [15:0] w_blk;
    logic        w_final;
    logic [7:0]  w_byte;
    logic        w_crc_on;
    logic        w_crc_rst;
    logic        w_last;
    logic        w_end;
    logic        w_dispatch;
    logic [7:0]  w_raw;
    logic [30:0] w_prod;
    logic [30:0] w_qsum;
    logic [16:0] w_s1;
    logic [15:0] w_nl;
    logic [16:0] w_s2;
    logic [15:0] w_nh;
    logic [31:0] w_idat32;

    assign w_adv    = (r_phase != PH_IDLE) && (!r_ov || o_byte.ready);
    assign w_blkhdr = (r_phase == PH_RAW) && (r_blk_left == 16'd0);
    assign w_final  = (r_raw_left <= {14'd0, STORED_BLOCK_MAX});
    assign w_blk    = w_final ? r_raw_left[15:0] : STORED_BLOCK_MAX;
    assign w_idat32 = {1'b0, r_idat};

    // scanline byte: filter byte or 565 channel widened to 8 bits
    always_comb begin
        case (r_ri)
            2'd0:    w_raw = 8'h00;
            2'd1:    w_raw = {r_cmd.pixel[15:11], r_cmd.pixel[15:13]};
            2'd2:    w_raw = {r_cmd.pixel[10:5], r_cmd.pixel[10:9]};
            default: w_raw = {r_cmd.pixel[4:0], r_cmd.pixel[4:2]};
        endcase
    end

    // Adler-32 step on the scanline byte
    always_comb begin
        w_s1 = {1'b0, r_adl} + {9'd0, w_raw};
        w_nl = (w_s1 >= ADLER_MOD) ? 16'(w_s1 - ADLER_MOD) : w_s1[15:0];
        w_s2 = {1'b0, r_adh} + {1'b0, w_nl};
        w_nh = (w_s2 >= ADLER_MOD) ? 16'(w_s2 - ADLER_MOD) : w_s2[15:0];
    end

    // byte selection for the current step
    always_comb begin
        w_byte    = 8'h00;
        w_crc_on  = 1'b0;
        w_crc_rst = 1'b0;
        w_last    = 1'b0;
        w_end     = 1'b0;
        case (r_phase)
            PH_HDR: begin
                case (r_idx)
                    6'd0:    w_byte = 8'h89;
                    6'd1:    w_byte = 8'h50;
                    6'd2:    w_byte = 8'h4E;
                    6'd3:    w_byte = 8'h47;
                    6'd4:    w_byte = 8'h0D;
                    6'd5:    w_byte = 8'h0A;
                    6'd6:    w_byte = 8'h1A;
                    6'd7:    w_byte = 8'h0A;
                    6'd11:   w_byte = 8'h0D;
                    6'd12:   w_byte = 8'h49;
                    6'd13:   w_byte = 8'h48;
                    6'd14:   w_byte = 8'h44;
                    6'd15:   w_byte = 8'h52;
                    6'd18:   w_byte = {1'b0, r_w[14:8]};
                    6'd19:   w_byte = r_w[7:0];
                    6'd22:   w_byte = {1'b0, r_h[14:8]};
                    6'd23:   w_byte = r_h[7:0];
                    6'd24:   w_byte = 8'h08;
                    6'd25:   w_byte = 8'h02;
                    6'd29:   w_byte = ~r_crc[31:24];
                    6'd30:   w_byte = ~r_crc[23:16];
                    6'd31:   w_byte = ~r_crc[15:8];
                    6'd32:   w_byte = ~r_crc[7:0];
                    6'd33:   w_byte = w_idat32[31:24];
                    6'd34:   w_byte = w_idat32[23:16];
                    6'd35:   w_byte = w_idat32[15:8];
                    6'd36:   w_byte = w_idat32[7:0];
                    6'd37:   w_byte = 8'h49;
                    6'd38:   w_byte = 8'h44;
                    6'd39:   w_byte = 8'h41;
                    6'd40:   w_byte = 8'h54;
                    6'd41:   w_byte = 8'h78;
                    6'd42:   w_byte = 8'h01;
                    default: w_byte = 8'h00;
                endcase
                w_crc_on  = (r_idx inside {[6'd12:6'd28], [6'd37:6'd42]});
                w_crc_rst = (r_idx == 6'd12) || (r_idx == 6'd37);
            end
            PH_RAW: begin
                w_crc_on = 1'b1;
                if (w_blkhdr) begin
                    case (r_bh)
                        3'd0:    w_byte = {7'd0, w_final};
                        3'd1:    w_byte = w_blk[7:0];
                        3'd2:    w_byte = w_blk[15:8];
                        3'd3:    w_byte = ~w_blk[7:0];
                        default: w_byte = ~w_blk[15:8];
                    endcase
                end else begin
                    w_byte = w_raw;
                    w_last = (r_ri == RAW_LAST) && !r_cmd.trailer;
                end
            end
            PH_TRL: begin
                case (r_idx)
                    6'd0:    w_byte = r_adh[15:8];
                    6'd1:    w_byte = r_adh[7:0];
                    6'd2:    w_byte = r_adl[15:8];
                    6'd3:    w_byte = r_adl[7:0];
                    6'd4:    w_byte = ~r_crc[31:24];
                    6'd5:    w_byte = ~r_crc[23:16];
                    6'd6:    w_byte = ~r_crc[15:8];
                    6'd7:    w_byte = ~r_crc[7:0];
                    6'd12:   w_byte = 8'h49;
                    6'd13:   w_byte = 8'h45;
                    6'd14:   w_byte = 8'h4E;
                    6'd15:   w_byte = 8'h44;
                    6'd16:   w_byte = ~r_crc[31:24];
                    6'd17:   w_byte = ~r_crc[23:16];
                    6'd18:   w_byte = ~r_crc[15:8];
                    6'd19:   w_byte = ~r_crc[7:0];
                    default: w_byte = 8'h00;
                endcase
                w_crc_on  = (r_idx inside {[6'd0:6'd3], [6'd12:6'd15]});
                w_crc_rst = (r_idx == 6'd12);
                w_last    = (r_idx == TRL_LAST);
                w_end     = (r_idx == TRL_LAST);
            end
            default: begin
                w_byte = 8'h00;
            end
        endcase
    end

    // take the next command when idle or right after the last byte of one
    assign w_dispatch = (r_phase == PH_IDLE) || (w_adv && w_last);
    assign o_cmd_pop  = w_dispatch && i_cmd_valid;

    // raw length, block count (divide by 2^16-1 via shift-add) and IDAT length
    assign w_prod = {16'd0, r_h} * {15'd0, r_rowlen};
    assign w_qsum = r_rawp + {16'd0, r_rawp[30:16]} + 31'd1;

    always_ff @(posedge i_clk) begin
        r_rowlen <= {r_w, 1'b0} + {1'b0, r_w} + 16'd1;
        r_raw    <= w_prod[29:0];
        r_rawp   <= {1'b0, r_raw} + {15'd0, STORED_BLOCK_MAX} - 31'd1;
        r_blocks <= w_qsum[30:16];
        r_idat   <= {1'b0, r_raw} + {14'd0, r_blocks, 2'b00} + {16'd0, r_blocks} + 31'd6;
    end

    // sequencer and checksum state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_idx      <= 6'd0;
            r_ri       <= 2'd0;
            r_bh       <= 3'd0;
            r_crc      <= CRC_SEED;
            r_adl      <= 16'd1;
            r_adh      <= 16'd0;
            r_blk_left <= 16'd0;
            r_raw_left <= 30'd0;
        end else begin
            if (w_adv) begin
                if (w_crc_on) begin
                    r_crc <= crc_byte(w_crc_rst ? CRC_SEED : r_crc, w_byte);
                end
                case (r_phase)
                    PH_HDR: begin
                        r_idx <= r_idx + 6'd1;
                        if (r_idx == HDR_LAST) begin
                            r_phase    <= PH_RAW;
                            r_ri       <= 2'd0;
                            r_raw_left <= r_raw;
                        end
                    end
                    PH_RAW: begin
                        if (w_blkhdr) begin
                            if (r_bh == BLK_LAST) begin
                                r_bh       <= 3'd0;
                                r_blk_left <= w_blk;
                            end else begin
                                r_bh <= r_bh + 3'd1;
                            end
                        end else begin
                            r_adl      <= w_nl;
                            r_adh      <= w_nh;
                            r_blk_left <= r_blk_left - 16'd1;
                            r_raw_left <= r_raw_left - 30'd1;
                            r_ri       <= r_ri + 2'd1;
                            if ((r_ri == RAW_LAST) && r_cmd.trailer) begin
                                r_phase <= PH_TRL;
                                r_idx   <= 6'd0;
                            end
                        end
                    end
                    PH_TRL: begin
                        r_idx <= r_idx + 6'd1;
                    end
                    default: begin
                        r_idx <= r_idx;
                    end
                endcase
            end
            if (w_dispatch) begin
                if (i_cmd_valid) begin
                    r_idx <= 6'd0;
                    r_bh  <= 3'd0;
                    r_ri  <= i_cmd.row_start ? 2'd0 : 2'd1;
                    if (i_cmd.start) begin
                        r_phase    <= PH_HDR;
                        r_blk_left <= 16'd0;
                        r_adl      <= 16'd1;
                        r_adh      <= 16'd0;
                    end else if (i_cmd.raw_on) begin
                        r_phase <= PH_RAW;
                    end else begin
                        r_phase <= PH_TRL;
                    end
                end else begin
                    r_phase <= PH_IDLE;
                end
            end
        end
    end

    // command payload and image size
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
            if (i_cmd.start) begin
                r_w <= i_cmd.width;
                r_h <= i_cmd.height;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= 1'b1;
        end else if (o_byte.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ob <= w_byte;
            r_ol <= w_last;
            r_oe <= w_end;
        end
    end

    assign o_byte.valid    = r_ov;
    assign o_byte.out_byte = r_ob;
    assign o_byte.run_last = r_ol;
    assign o_byte.file_end = r_oe;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oe) |-> r_ol)
        else $error("file end byte without run end");

    a_hdr_to_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR && r_idx == HDR_LAST && w_adv)
            |=> (r_phase == PH_RAW && r_blk_left == 16'd0))
        else $error("header did not hand over to a stored block");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> i_cmd_valid)
        else $error("command popped from an empty queue");

endmodule
`default_nettype wire

[design/rgb565_stored_png_stream_unit.sv]
`default_nettype none
// Path: pixel -> command queue -> byte sequencer -> registered byte output.
// Throughput: one byte per cycle while the byte sink is ready and commands
// are queued: 3 bytes per pixel, 4 at a row start, 5 more at a stored block
// header; the byte sequencer sets this. First pixel 52 bytes, last 20 more.
// Reset: synchronous, active low; width and height registers reset to 1.
// ============================================================================
// rgb565_stored_png_stream_unit
// RGB565 pixels in, uncompressed 24-bit PNG file bytes out (zlib stored
// blocks, CRC-32 and Adler-32); size registers on an APB port.
// ============================================================================
module rgb565_stored_png_stream_unit import rpng_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rpng_pix_if.sink         i_pix,
    rpng_byte_if.source      o_byte,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [14:0] r_width;
    logic [14:0] r_height;
    logic        w_wr;
    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_cvalid;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    // configuration registers
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 15'd1;
            r_height <= 15'd1;
        end else if (w_wr) begin
            if (paddr[2] == REG_WIDTH) begin
                r_width <= pwdata[14:0];
            end else begin
                r_height <= pwdata[14:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? {17'd0, r_height} : {17'd0, r_width};

    rpng_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .i_pix        (i_pix),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_cmd        (w_cmd_in)
    );

    rpng_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cvalid),
        .o_cmd   (w_cmd_out)
    );

    rpng_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cvalid),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_pop),
        .o_byte      (o_byte)
    );

endmodule
`default_nettype wire
